// ===== rtl/core/snqs_pkg.sv =====
// Shared types, codes and constants of the note queue sequencer.
package snqs_pkg;

   localparam int CHANNELS_DEF    = 4;
   localparam int QUEUE_DEPTH_DEF = 8;

   localparam logic [3:0] CHAN_RESET = 4'd4;

   localparam logic [1:0] REQ_RESET  = 2'd0;
   localparam logic [1:0] REQ_QUEUE  = 2'd1;
   localparam logic [1:0] REQ_VOLUME = 2'd2;
   localparam logic [1:0] REQ_TICK   = 2'd3;

   localparam logic [1:0] KIND_ACK  = 2'd0;
   localparam logic [1:0] KIND_FULL = 2'd1;
   localparam logic [1:0] KIND_VOL  = 2'd2;

   localparam int FREQ_LOW  = 100;
   localparam int FREQ_WRAP = 1100;
   localparam int FREQ_HIGH = 1200;
   localparam int FREQ_MAX  = 4000;
   localparam int VOL_MAX   = 127;

   typedef struct packed {
      logic [6:0]  volume;
      logic [7:0]  sound_type;
      logic [15:0] time_cs;
      logic [15:0] slide;
      logic [15:0] frequency;
   } note_entry_type;

   typedef struct packed {
      logic       latch_req;
      logic       next_chan;
      logic       do_reset;
      logic       do_qwrite;
      logic       do_qread;
      logic       do_qload;
      logic       do_setvol;
      logic       div_start;
      logic       div_step;
      logic       div_end;
      logic       do_end;
      logic       do_fade;
      logic       do_slide;
      logic       emit;
      logic [1:0] emit_kind;
   } dp_cmd_type;

   typedef struct packed {
      logic       is_tick;
      logic [1:0] req_code;
      logic       chan_bad;
      logic       active;
      logic       fill_zero;
      logic       ticks_zero;
      logic       fade_nz;
      logic       slide_nz;
      logic       vol_direct;
      logic       chan_done;
      logic       out_free;
      logic       div_last;
   } dp_stat_type;

endpackage

// ===== rtl/core/snqs_if.sv =====
// Request and response channel interfaces of the note queue sequencer.
interface snqs_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  req_type;
   logic [2:0]  chan;
   logic [15:0] frequency;
   logic [15:0] slide;
   logic [15:0] time_cs;
   logic [7:0]  sound_type;
   logic [6:0]  volume;

   modport source (output valid, req_type, chan, frequency, slide, time_cs, sound_type,
                   volume, input ready);
   modport sink (input valid, req_type, chan, frequency, slide, time_cs, sound_type,
                 volume, output ready);
endinterface

interface snqs_rsp_if;
   logic        valid;
   logic        ready;
   logic [1:0]  kind;
   logic [2:0]  out_chan;
   logic [15:0] out_frequency;
   logic [7:0]  out_type;
   logic [6:0]  out_volume;
   logic        playing;
   logic        status;
   logic [4:0]  note_count;
   logic        last;

   modport source (output valid, kind, out_chan, out_frequency, out_type, out_volume,
                   playing, status, note_count, last, input ready);
   modport sink (input valid, kind, out_chan, out_frequency, out_type, out_volume,
                 playing, status, note_count, last, output ready);
endinterface

// ===== rtl/core/snqs_ctrl.sv =====
// Controller state machine: sequences requests, ticks and result emission.
module snqs_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  snqs_pkg::dp_stat_type   stat,
   output snqs_pkg::dp_cmd_type    cmd
);

   typedef enum logic [11:0] {
      ST_IDLE     = 12'b000000000001,
      ST_DECODE   = 12'b000000000010,
      ST_QWRITE   = 12'b000000000100,
      ST_QREAD    = 12'b000000001000,
      ST_QLOAD    = 12'b000000010000,
      ST_EMIT     = 12'b000000100000,
      ST_ACK      = 12'b000001000000,
      ST_DIV      = 12'b000010000000,
      ST_DIVEND   = 12'b000100000000,
      ST_TK_CHK   = 12'b001000000000,
      ST_TK_SLIDE = 12'b010000000000,
      ST_TK_NEXT  = 12'b100000000000
   } state_type;

   state_type  state_ff, state_in;
   state_type  ret_ff, ret_in;
   logic [1:0] kind_ff, kind_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ret_ff   <= ST_IDLE;
         kind_ff  <= snqs_pkg::KIND_ACK;
      end else begin
         state_ff <= state_in;
         ret_ff   <= ret_in;
         kind_ff  <= kind_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      state_in      = state_ff;
      ret_in        = ret_ff;
      kind_in       = kind_ff;
      cmd           = '0;
      cmd.emit_kind = kind_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.latch_req = 1'b1;
               state_in      = ST_DECODE;
            end
         end
         ST_DECODE: begin
            if (stat.is_tick) begin
               state_in = ST_TK_CHK;
            end else if (stat.chan_bad) begin
               state_in = ST_ACK;
            end else begin
               case (stat.req_code)
                  snqs_pkg::REQ_RESET: begin
                     cmd.do_reset = 1'b1;
                     kind_in      = snqs_pkg::KIND_FULL;
                     ret_in       = ST_ACK;
                     state_in     = ST_EMIT;
                  end
                  snqs_pkg::REQ_QUEUE: begin
                     state_in = ST_QWRITE;
                  end
                  snqs_pkg::REQ_VOLUME: begin
                     if (!stat.active) begin
                        state_in = ST_ACK;
                     end else if (stat.vol_direct) begin
                        cmd.do_setvol = 1'b1;
                        kind_in       = snqs_pkg::KIND_VOL;
                        ret_in        = ST_ACK;
                        state_in      = ST_EMIT;
                     end else begin
                        cmd.div_start = 1'b1;
                        state_in      = ST_DIV;
                     end
                  end
                  default: begin
                     state_in = ST_ACK;
                  end
               endcase
            end
         end
         ST_QWRITE: begin
            cmd.do_qwrite = 1'b1;
            state_in      = stat.active ? ST_ACK : ST_QREAD;
         end
         ST_QREAD: begin
            cmd.do_qread = 1'b1;
            state_in     = ST_QLOAD;
         end
         ST_QLOAD: begin
            cmd.do_qload = 1'b1;
            kind_in      = snqs_pkg::KIND_FULL;
            ret_in       = stat.is_tick ? ST_TK_NEXT : ST_ACK;
            state_in     = ST_EMIT;
         end
         ST_EMIT: begin
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ret_ff;
            end
         end
         ST_ACK: begin
            cmd.emit_kind = snqs_pkg::KIND_ACK;
            if (stat.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (stat.div_last) begin
               state_in = ST_DIVEND;
            end
         end
         ST_DIVEND: begin
            cmd.div_end = 1'b1;
            state_in    = ST_ACK;
         end
         ST_TK_CHK: begin
            if (stat.chan_done) begin
               state_in = ST_ACK;
            end else if (!stat.active) begin
               state_in = ST_TK_NEXT;
            end else if (stat.ticks_zero) begin
               cmd.do_end = 1'b1;
               if (stat.fill_zero) begin
                  kind_in  = snqs_pkg::KIND_FULL;
                  ret_in   = ST_TK_NEXT;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_QREAD;
               end
            end else begin
               cmd.do_fade = 1'b1;
               if (stat.fade_nz) begin
                  kind_in  = snqs_pkg::KIND_VOL;
                  ret_in   = ST_TK_SLIDE;
                  state_in = ST_EMIT;
               end else begin
                  state_in = ST_TK_SLIDE;
               end
            end
         end
         ST_TK_SLIDE: begin
            if (stat.slide_nz) begin
               cmd.do_slide = 1'b1;
               kind_in      = snqs_pkg::KIND_FULL;
               ret_in       = ST_TK_NEXT;
               state_in     = ST_EMIT;
            end else begin
               state_in = ST_TK_NEXT;
            end
         end
         ST_TK_NEXT: begin
            cmd.next_chan = 1'b1;
            state_in      = ST_TK_CHK;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

// ===== rtl/core/snqs_dp.sv =====
// Datapath: channel state, note memory, ramp divider and response register.
module snqs_dp #(
   parameter int CHANNELS    = snqs_pkg::CHANNELS_DEF,
   parameter int QUEUE_DEPTH = snqs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_wr_en,
   input  logic [3:0]            csr_wr_data,
   input  logic [1:0]            req_type,
   input  logic [2:0]            req_chan,
   input  logic [15:0]           req_frequency,
   input  logic [15:0]           req_slide,
   input  logic [15:0]           req_time_cs,
   input  logic [7:0]            req_sound_type,
   input  logic [6:0]            req_volume,
   input  snqs_pkg::dp_cmd_type  cmd,
   output snqs_pkg::dp_stat_type stat,
   input  logic                  rsp_ready,
   output logic                  rsp_valid,
   output logic [1:0]            rsp_kind,
   output logic [2:0]            rsp_chan,
   output logic [15:0]           rsp_frequency,
   output logic [7:0]            rsp_type,
   output logic [6:0]            rsp_volume,
   output logic                  rsp_playing,
   output logic                  rsp_status,
   output logic [4:0]            rsp_note_count,
   output logic                  rsp_last
);

   localparam int CIW   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int QW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int FW    = $clog2(QUEUE_DEPTH + 1);
   localparam int SW    = FW + 1;
   localparam int DEPTH = CHANNELS * QUEUE_DEPTH;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

   // configuration and latched request
   logic [3:0]  csr_ff;
   logic [1:0]  rq_type_ff;
   logic [2:0]  rq_chan_ff;
   logic [15:0] rq_freq_ff;
   logic [15:0] rq_slide_ff;
   logic [15:0] rq_time_ff;
   logic [7:0]  rq_styp_ff;
   logic [6:0]  rq_vol_ff;
   logic [3:0]  idx_ff;

   // per-channel state
   logic [QW-1:0]     head_ff   [CHANNELS];
   logic [FW-1:0]     fill_ff   [CHANNELS];
   logic              active_ff [CHANNELS];
   logic [14:0]       ticks_ff  [CHANNELS];
   logic [15:0]       freq_ff   [CHANNELS];
   logic [15:0]       slide_ff  [CHANNELS];
   logic [7:0]        type_ff   [CHANNELS];
   logic [6:0]        vol_ff    [CHANNELS];
   logic signed [7:0] step_ff   [CHANNELS];
   logic [6:0]        target_ff [CHANNELS];

   logic [QW-1:0]     head_in;
   logic [FW-1:0]     fill_in;
   logic              active_in;
   logic [14:0]       ticks_in;
   logic [15:0]       freq_in;
   logic [15:0]       slide_in;
   logic [7:0]        type_in;
   logic [6:0]        vol_in;
   logic signed [7:0] step_in;
   logic [6:0]        target_in;
   logic              chan_wr;

   // note memory
   snqs_pkg::note_entry_type mem [DEPTH];
   snqs_pkg::note_entry_type rd_ff;
   snqs_pkg::note_entry_type wr_entry;

   // divider
   logic [6:0] dq_ff, dq_in;
   logic [6:0] rem_ff, rem_in;
   logic [2:0] cnt_ff, cnt_in;
   logic       neg_ff, neg_in;

   // response register
   logic        rv_ff, rv_in;
   logic [1:0]  rk_ff;
   logic [2:0]  rc_ff;
   logic [15:0] rf_ff;
   logic [7:0]  rt_ff;
   logic [6:0]  rvol_ff;
   logic        rp_ff;
   logic        rs_ff;
   logic [4:0]  rn_ff;
   logic        rl_ff;

   logic [CIW-1:0]    cidx;
   logic [3:0]        n_chan;
   logic [QW-1:0]     cur_head;
   logic [FW-1:0]     cur_fill;
   logic              cur_active;
   logic [14:0]       cur_ticks;
   logic [15:0]       cur_freq;
   logic [15:0]       cur_slide;
   logic [7:0]        cur_type;
   logic [6:0]        cur_vol;
   logic signed [7:0] cur_step;
   logic [6:0]        cur_target;
   logic              fill_full;
   logic [SW-1:0]     slot_sum;
   logic [QW-1:0]     wslot;
   logic [QW-1:0]     head_inc;
   logic [AW-1:0]     wr_addr;
   logic [AW-1:0]     rd_addr;
   logic [15:0]       half_slide;
   logic [14:0]       rq_ticks;
   logic signed [9:0] fade_v;
   logic signed [9:0] fade_t;
   logic signed [9:0] fade_h;
   logic              fade_hit;
   logic [6:0]        fade_res;
   logic signed [17:0] sl_0;
   logic signed [17:0] sl_1;
   logic signed [17:0] sl_2;
   logic [15:0]       sl_res;
   logic [7:0]        rem_sh;
   logic              rem_ge;
   logic [6:0]        quo;
   logic signed [7:0] step_res;
   logic              ack_status;

   assign cidx       = idx_ff[CIW-1:0];
   assign n_chan     = (csr_ff > 4'(CHANNELS)) ? 4'(CHANNELS) : csr_ff;
   assign cur_head   = head_ff[cidx];
   assign cur_fill   = fill_ff[cidx];
   assign cur_active = active_ff[cidx];
   assign cur_ticks  = ticks_ff[cidx];
   assign cur_freq   = freq_ff[cidx];
   assign cur_slide  = slide_ff[cidx];
   assign cur_type   = type_ff[cidx];
   assign cur_vol    = vol_ff[cidx];
   assign cur_step   = step_ff[cidx];
   assign cur_target = target_ff[cidx];
   assign fill_full  = (cur_fill == FW'(QUEUE_DEPTH));
   assign rq_ticks   = rq_time_ff[15:1];

   assign slot_sum = SW'(cur_head) + SW'(cur_fill);
   assign wslot    = (slot_sum >= SW'(QUEUE_DEPTH)) ? QW'(slot_sum - SW'(QUEUE_DEPTH))
                                                    : QW'(slot_sum);
   assign head_inc = (cur_head == QW'(QUEUE_DEPTH - 1)) ? '0 : QW'(cur_head + 1'b1);
   assign wr_addr  = AW'(AW'(cidx) * AW'(QUEUE_DEPTH) + AW'(wslot));
   assign rd_addr  = AW'(AW'(cidx) * AW'(QUEUE_DEPTH) + AW'(cur_head));

   always_comb begin
      half_slide = {rq_slide_ff[15], rq_slide_ff[15:1]};
      if ((rq_slide_ff != 16'd0) && (half_slide == 16'd0)) begin
         half_slide = 16'd1;
      end
      wr_entry.frequency  = rq_freq_ff;
      wr_entry.slide      = half_slide;
      wr_entry.time_cs    = rq_time_ff;
      wr_entry.sound_type = rq_styp_ff;
      wr_entry.volume     = rq_vol_ff;
   end

   // linear fade
   always_comb begin
      fade_v   = $signed({3'b000, cur_vol}) + $signed({{2{cur_step[7]}}, cur_step});
      fade_t   = $signed({3'b000, cur_target});
      fade_hit = (!cur_step[7] && (fade_v >= fade_t)) || (cur_step[7] && (fade_v <= fade_t));
      fade_h   = fade_hit ? fade_t : fade_v;
      if (fade_h < 10'sd0) begin
         fade_res = 7'd0;
      end else if (fade_h > $signed(10'(snqs_pkg::VOL_MAX))) begin
         fade_res = 7'(snqs_pkg::VOL_MAX);
      end else begin
         fade_res = fade_h[6:0];
      end
   end

   // frequency slide with wrap
   always_comb begin
      sl_0 = $signed({2'b00, cur_freq}) + $signed({{2{cur_slide[15]}}, cur_slide});
      sl_1 = (sl_0 < $signed(18'(snqs_pkg::FREQ_LOW))) ?
             sl_0 + $signed(18'(snqs_pkg::FREQ_WRAP)) : sl_0;
      sl_2 = (sl_1 > $signed(18'(snqs_pkg::FREQ_HIGH))) ?
             sl_1 - $signed(18'(snqs_pkg::FREQ_WRAP)) : sl_1;
      if ((sl_2 > $signed(18'(snqs_pkg::FREQ_MAX))) || (sl_2 < 18'sd0)) begin
         sl_res = 16'd0;
      end else begin
         sl_res = sl_2[15:0];
      end
   end

   // restoring divider, one quotient bit per cycle
   assign rem_sh   = {rem_ff, dq_ff[6]};
   assign rem_ge   = ({8'd0, rem_sh} >= {1'b0, rq_ticks});
   assign quo      = (dq_ff == 7'd0) ? 7'd1 : dq_ff;
   assign step_res = neg_ff ? -$signed({1'b0, quo}) : $signed({1'b0, quo});

   always_comb begin
      dq_in  = dq_ff;
      rem_in = rem_ff;
      cnt_in = cnt_ff;
      neg_in = neg_ff;
      if (cmd.div_start) begin
         neg_in = (rq_vol_ff < cur_vol);
         dq_in  = (rq_vol_ff < cur_vol) ? 7'(cur_vol - rq_vol_ff) : 7'(rq_vol_ff - cur_vol);
         rem_in = 7'd0;
         cnt_in = 3'd6;
      end else if (cmd.div_step) begin
         rem_in = rem_ge ? 7'(rem_sh - rq_ticks[7:0]) : rem_sh[6:0];
         dq_in  = {dq_ff[5:0], rem_ge};
         cnt_in = 3'(cnt_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      dq_ff  <= dq_in;
      rem_ff <= rem_in;
      cnt_ff <= cnt_in;
      neg_ff <= neg_in;
   end

   // selected channel update
   always_comb begin
      head_in   = cur_head;
      fill_in   = cur_fill;
      active_in = cur_active;
      ticks_in  = cur_ticks;
      freq_in   = cur_freq;
      slide_in  = cur_slide;
      type_in   = cur_type;
      vol_in    = cur_vol;
      step_in   = cur_step;
      target_in = cur_target;
      chan_wr   = cmd.do_reset | cmd.do_qwrite | cmd.do_qload | cmd.do_setvol |
                  cmd.div_end | cmd.do_end | cmd.do_fade | cmd.do_slide;
      if (cmd.do_reset) begin
         step_in   = '0;
         target_in = '0;
         active_in = 1'b0;
         ticks_in  = '0;
         fill_in   = '0;
         head_in   = '0;
      end
      if (cmd.do_qwrite && !fill_full) begin
         fill_in = FW'(cur_fill + 1'b1);
      end
      if (cmd.do_qload) begin
         freq_in   = rd_ff.frequency;
         slide_in  = rd_ff.slide;
         ticks_in  = rd_ff.time_cs[15:1];
         type_in   = rd_ff.sound_type;
         vol_in    = rd_ff.volume;
         step_in   = '0;
         active_in = 1'b1;
         head_in   = head_inc;
         fill_in   = FW'(cur_fill - 1'b1);
      end
      if (cmd.do_setvol) begin
         vol_in  = rq_vol_ff;
         step_in = '0;
      end
      if (cmd.div_end) begin
         target_in = rq_vol_ff;
         step_in   = step_res;
      end
      if (cmd.do_end) begin
         active_in = 1'b0;
         if ((cur_fill == '0) && (cur_freq > 16'(snqs_pkg::FREQ_MAX))) begin
            freq_in = 16'd0;
         end
      end
      if (cmd.do_fade) begin
         ticks_in = 15'(cur_ticks - 1'b1);
         if (cur_step != 8'sd0) begin
            vol_in = fade_res;
            if (fade_hit) begin
               step_in = '0;
            end
         end
      end
      if (cmd.do_slide) begin
         freq_in = sl_res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < CHANNELS; i++) begin
            head_ff[i]   <= '0;
            fill_ff[i]   <= '0;
            active_ff[i] <= 1'b0;
            ticks_ff[i]  <= '0;
            freq_ff[i]   <= '0;
            slide_ff[i]  <= '0;
            type_ff[i]   <= '0;
            vol_ff[i]    <= '0;
            step_ff[i]   <= '0;
            target_ff[i] <= '0;
         end
      end else if (chan_wr) begin
         head_ff[cidx]   <= head_in;
         fill_ff[cidx]   <= fill_in;
         active_ff[cidx] <= active_in;
         ticks_ff[cidx]  <= ticks_in;
         freq_ff[cidx]   <= freq_in;
         slide_ff[cidx]  <= slide_in;
         type_ff[cidx]   <= type_in;
         vol_ff[cidx]    <= vol_in;
         step_ff[cidx]   <= step_in;
         target_ff[cidx] <= target_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.do_qwrite && !fill_full) begin
         mem[wr_addr] <= wr_entry;
      end
      if (cmd.do_qread) begin
         rd_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= snqs_pkg::CHAN_RESET;
         idx_ff <= '0;
      end else begin
         if (csr_wr_en) begin
            csr_ff <= csr_wr_data;
         end
         if (cmd.latch_req) begin
            idx_ff <= (req_type == snqs_pkg::REQ_TICK) ? 4'd0 : {1'b0, req_chan};
         end else if (cmd.next_chan) begin
            idx_ff <= 4'(idx_ff + 1'b1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.latch_req) begin
         rq_type_ff  <= req_type;
         rq_chan_ff  <= req_chan;
         rq_freq_ff  <= req_frequency;
         rq_slide_ff <= req_slide;
         rq_time_ff  <= req_time_cs;
         rq_styp_ff  <= req_sound_type;
         rq_vol_ff   <= req_volume;
      end
   end

   // response register
   assign ack_status = (rq_type_ff == snqs_pkg::REQ_VOLUME) && !cur_active;
   assign rv_in      = cmd.emit | (rv_ff & ~rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else begin
         rv_ff <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rk_ff <= cmd.emit_kind;
         if (cmd.emit_kind != snqs_pkg::KIND_ACK) begin
            rc_ff   <= idx_ff[2:0];
            rf_ff   <= cur_freq;
            rt_ff   <= cur_type;
            rvol_ff <= cur_vol;
            rp_ff   <= cur_active;
            rs_ff   <= 1'b0;
            rn_ff   <= 5'd0;
            rl_ff   <= 1'b0;
         end else if (rq_type_ff == snqs_pkg::REQ_TICK) begin
            rc_ff   <= 3'd0;
            rf_ff   <= 16'd0;
            rt_ff   <= 8'd0;
            rvol_ff <= 7'd0;
            rp_ff   <= 1'b0;
            rs_ff   <= 1'b0;
            rn_ff   <= 5'd0;
            rl_ff   <= 1'b1;
         end else if (stat.chan_bad) begin
            rc_ff   <= rq_chan_ff;
            rf_ff   <= 16'd0;
            rt_ff   <= 8'd0;
            rvol_ff <= 7'd0;
            rp_ff   <= 1'b0;
            rs_ff   <= 1'b1;
            rn_ff   <= 5'd0;
            rl_ff   <= 1'b1;
         end else begin
            rc_ff   <= rq_chan_ff;
            rf_ff   <= cur_freq;
            rt_ff   <= cur_type;
            rvol_ff <= cur_active ? cur_vol : 7'd0;
            rp_ff   <= cur_active;
            rs_ff   <= ack_status;
            rn_ff   <= 5'(cur_fill) + 5'(cur_active);
            rl_ff   <= 1'b1;
         end
      end
   end

   assign rsp_valid      = rv_ff;
   assign rsp_kind       = rk_ff;
   assign rsp_chan       = rc_ff;
   assign rsp_frequency  = rf_ff;
   assign rsp_type       = rt_ff;
   assign rsp_volume     = rvol_ff;
   assign rsp_playing    = rp_ff;
   assign rsp_status     = rs_ff;
   assign rsp_note_count = rn_ff;
   assign rsp_last       = rl_ff;

   assign stat.is_tick    = (rq_type_ff == snqs_pkg::REQ_TICK);
   assign stat.req_code   = rq_type_ff;
   assign stat.chan_bad   = ({1'b0, rq_chan_ff} >= n_chan);
   assign stat.active     = cur_active;
   assign stat.fill_zero  = (cur_fill == '0);
   assign stat.ticks_zero = (cur_ticks == '0);
   assign stat.fade_nz    = (cur_step != 8'sd0);
   assign stat.slide_nz   = (cur_slide != 16'd0);
   assign stat.vol_direct = (rq_ticks == 15'd0) || (rq_vol_ff == cur_vol);
   assign stat.chan_done  = (idx_ff >= n_chan);
   assign stat.out_free   = ~rv_ff | rsp_ready;
   assign stat.div_last   = (cnt_ff == 3'd0);

endmodule

// ===== rtl/core/sound_note_queue_sequencer_unit.sv =====
// Top level of the note queue sequencer: controller plus datapath.
// A request is taken only when the previous one has loaded its acknowledgement.
// Reset, queue and volume requests each end in an acknowledgement (volume ramp: the divider runs first).
// A tick visits each channel in use in turn, then ends in an acknowledgement.
// Every result waits in a one-deep output register; a stalled consumer stalls the FSM.
// Reset is synchronous: clears channel state, sets channels_in_use to 4, not note memory.
module sound_note_queue_sequencer_unit #(
   parameter int CHANNELS    = snqs_pkg::CHANNELS_DEF,
   parameter int QUEUE_DEPTH = snqs_pkg::QUEUE_DEPTH_DEF
) (
   input  logic        clock,
   input  logic        reset,
   snqs_req_if.sink    req_ch,
   snqs_rsp_if.source  rsp_ch,
   input  logic        csr_wr_en,
   input  logic [3:0]  csr_wr_data
);

   snqs_pkg::dp_cmd_type  cmd;
   snqs_pkg::dp_stat_type stat;

   snqs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   snqs_dp #(
      .CHANNELS    (CHANNELS),
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_wr_en      (csr_wr_en),
      .csr_wr_data    (csr_wr_data),
      .req_type       (req_ch.req_type),
      .req_chan       (req_ch.chan),
      .req_frequency  (req_ch.frequency),
      .req_slide      (req_ch.slide),
      .req_time_cs    (req_ch.time_cs),
      .req_sound_type (req_ch.sound_type),
      .req_volume     (req_ch.volume),
      .cmd            (cmd),
      .stat           (stat),
      .rsp_ready      (rsp_ch.ready),
      .rsp_valid      (rsp_ch.valid),
      .rsp_kind       (rsp_ch.kind),
      .rsp_chan       (rsp_ch.out_chan),
      .rsp_frequency  (rsp_ch.out_frequency),
      .rsp_type       (rsp_ch.out_type),
      .rsp_volume     (rsp_ch.out_volume),
      .rsp_playing    (rsp_ch.playing),
      .rsp_status     (rsp_ch.status),
      .rsp_note_count (rsp_ch.note_count),
      .rsp_last       (rsp_ch.last)
   );

endmodule

// ===== rtl/core/snqs_checker.sv =====
// Port-level assertions for the note queue sequencer, bound to the top level.
module snqs_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [1:0]  rsp_kind,
   input logic        rsp_playing,
   input logic        rsp_status,
   input logic [4:0]  rsp_note_count,
   input logic        rsp_last
);

   // one request in flight at a time
   a_one_request: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request taken while another is in flight");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_kind) && $stable(rsp_last)))
      else $error("stalled response changed");

   // last marks the acknowledgement and nothing else
   a_last_is_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_last == (rsp_kind == snqs_pkg::KIND_ACK)))
      else $error("last flag does not match acknowledgement kind");

   // an error acknowledgement reports nothing playing
   a_err_ack: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> (rsp_last && !rsp_playing && (rsp_note_count == 5'd0)))
      else $error("error acknowledgement carries channel data");

endmodule

bind sound_note_queue_sequencer_unit snqs_checker u_snqs_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_kind       (rsp_ch.kind),
   .rsp_playing    (rsp_ch.playing),
   .rsp_status     (rsp_ch.status),
   .rsp_note_count (rsp_ch.note_count),
   .rsp_last       (rsp_ch.last)
);
